// File: src/three_stage_pipeline_core_step_macros.svh
// Assertion macros used by the core step back end.
// Depends on nothing; included by tsp_back, the module that carries assertions.
`ifndef THREE_STAGE_PIPELINE_CORE_STEP_MACROS_SVH
`define THREE_STAGE_PIPELINE_CORE_STEP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/tsp_pkg.sv
// Shared types and codes for the three-stage core step block.
// Depends on nothing; imported by every module of the block.
package tsp_pkg;

	localparam logic [3:0] ACT_ADD     = 4'd0;
	localparam logic [3:0] ACT_ADDI    = 4'd1;
	localparam logic [3:0] ACT_SUB     = 4'd2;
	localparam logic [3:0] ACT_MUL     = 4'd3;
	localparam logic [3:0] ACT_DIV     = 4'd4;
	localparam logic [3:0] ACT_B       = 4'd5;
	localparam logic [3:0] ACT_BEQ     = 4'd6;
	localparam logic [3:0] ACT_BNQ     = 4'd7;
	localparam logic [3:0] ACT_END     = 4'd8;
	localparam logic [3:0] ACT_PRELOAD = 4'd9;

	localparam logic [2:0] CLS_NONE    = 3'd0;
	localparam logic [2:0] CLS_ALU     = 3'd1;
	localparam logic [2:0] CLS_DIV     = 3'd2;
	localparam logic [2:0] CLS_BRANCH  = 3'd3;
	localparam logic [2:0] CLS_END     = 3'd4;
	localparam logic [2:0] CLS_PRELOAD = 3'd5;

	typedef struct packed {
		logic [2:0]  cls;
		logic [3:0]  action;
		logic [3:0]  dest_reg;
		logic [3:0]  src_reg_a;
		logic [3:0]  src_reg_b;
		logic [31:0] immediate;
		logic [7:0]  branch_target;
	} q_entry_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

endpackage

// File: src/three_stage_pipeline_core_step.sv
// Top level of the three-stage core step block: one decoded instruction in,
// one or two occupancy reports out.
//
// Usage: the input channel (in_valid/in_ready) carries one decoded instruction
// per transaction; the output channel (out_valid/out_ready) carries one report
// per transaction, with last marking the final report of an instruction.
// Branches give two reports, all other instructions one.
// A two-entry queue decouples the input side from the execution sequencer,
// so instructions keep being accepted while a report waits to be taken.
// A report passes through the queue, the instruction and operand registers and
// the output register before it reaches out_valid; a branch's second report
// comes from the S_BR2 state, and a divide by a non-zero divisor waits in
// S_DIV for the 32-step divider (one quotient bit per cycle). One instruction
// is sequenced at a time. Reset marks every register of the register file as
// unwritten, so it reads as zero, clears the program counter, stage occupancy
// and halt flag and sets the cycle count to all ones. When the receiver stalls,
// the report is held in the output register and the sequencer waits; the queue
// then fills and in_ready falls.
// Depends on tsp_pkg, tsp_front, tsp_div and tsp_back.
module three_stage_pipeline_core_step
	import tsp_pkg::*;
#(
	parameter int NUM_REGS   = 10,
	parameter int PROG_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         action,
	input  logic [3:0]         dest_reg,
	input  logic [3:0]         src_reg_a,
	input  logic [3:0]         src_reg_b,
	input  logic signed [31:0] immediate,
	input  logic [7:0]         branch_target,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        cycle_number,
	output logic               fetch_valid,
	output logic [7:0]         fetch_index,
	output logic               execute_valid,
	output logic [7:0]         execute_index,
	output logic               writeback_valid,
	output logic [7:0]         writeback_index,
	output logic [7:0]         next_index,
	output logic signed [31:0] written_value,
	output logic               divide_by_zero,
	output logic               halted,
	output logic               last
);

	logic     q_valid;
	q_entry_t q_head;
	logic     q_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;

	tsp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.dest_reg      (dest_reg),
		.src_reg_a     (src_reg_a),
		.src_reg_b     (src_reg_b),
		.immediate     (immediate),
		.branch_target (branch_target),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop)
	);

	tsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tsp_back #(
		.NUM_REGS   (NUM_REGS),
		.PROG_DEPTH (PROG_DEPTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_head          (q_head),
		.q_pop           (q_pop),
		.div_req         (div_req),
		.div_rsp         (div_rsp),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.cycle_number    (cycle_number),
		.fetch_valid     (fetch_valid),
		.fetch_index     (fetch_index),
		.execute_valid   (execute_valid),
		.execute_index   (execute_index),
		.writeback_valid (writeback_valid),
		.writeback_index (writeback_index),
		.next_index      (next_index),
		.written_value   (written_value),
		.divide_by_zero  (divide_by_zero),
		.halted          (halted),
		.last            (last)
	);

endmodule

// File: src/tsp_front.sv
// Front end: accepts instructions, classifies them and holds them in a two-entry queue.
// Depends on tsp_pkg.
module tsp_front
	import tsp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [3:0]        action,
	input  logic [3:0]        dest_reg,
	input  logic [3:0]        src_reg_a,
	input  logic [3:0]        src_reg_b,
	input  logic signed [31:0] immediate,
	input  logic [7:0]        branch_target,
	output logic              q_valid,
	output q_entry_t          q_head,
	input  logic              q_pop
);

	q_entry_t   entry_q [2];
	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       push;
	logic [2:0] cls;

	always_comb begin
		case (action)
			ACT_ADD, ACT_ADDI, ACT_SUB, ACT_MUL: cls = CLS_ALU;
			ACT_DIV:                             cls = CLS_DIV;
			ACT_B, ACT_BEQ, ACT_BNQ:             cls = CLS_BRANCH;
			ACT_END:                             cls = CLS_END;
			ACT_PRELOAD:                         cls = CLS_PRELOAD;
			default:                             cls = CLS_NONE;
		endcase
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_head   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{cls: cls, action: action, dest_reg: dest_reg,
				src_reg_a: src_reg_a, src_reg_b: src_reg_b,
				immediate: immediate, branch_target: branch_target};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !q_pop) count_q <= count_q + 2'd1;
			else if (!push && q_pop) count_q <= count_q - 2'd1;
		end
	end

endmodule

// File: src/tsp_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on tsp_pkg.
module tsp_div
	import tsp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
			den_q <= req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
			rem_q <= 32'd0;
			neg_q <= req.dividend[31] ^ req.divisor[31];
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

// File: src/tsp_back.sv
// Back end: register file, pipeline occupancy, sequencing of each instruction and result register.
// Depends on tsp_pkg and the assertion macros; drives the divider through tsp_pkg structs.
`include "three_stage_pipeline_core_step_macros.svh"
module tsp_back
	import tsp_pkg::*;
#(
	parameter int NUM_REGS   = 10,
	parameter int PROG_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  q_entry_t           q_head,
	output logic               q_pop,
	output div_req_t           div_req,
	input  div_rsp_t           div_rsp,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        cycle_number,
	output logic               fetch_valid,
	output logic [7:0]         fetch_index,
	output logic               execute_valid,
	output logic [7:0]         execute_index,
	output logic               writeback_valid,
	output logic [7:0]         writeback_index,
	output logic [7:0]         next_index,
	output logic signed [31:0] written_value,
	output logic               divide_by_zero,
	output logic               halted,
	output logic               last
);

	localparam int PW = $clog2(PROG_DEPTH);
	localparam int RW = $clog2(NUM_REGS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_BR2  = 2'd3;

	typedef struct packed {
		logic          v;
		logic [PW-1:0] idx;
	} slot_t;

	function automatic logic [7:0] idx8(input logic [PW-1:0] x);
		logic [PW+7:0] w;
		w = {8'd0, x};
		return w[7:0];
	endfunction

	logic [31:0]   rf_q [NUM_REGS];
	logic [NUM_REGS-1:0] rvalid_q;
	logic [31:0]   rda_q;
	logic [31:0]   rdb_q;
	logic          rva_q;
	logic          rvb_q;
	q_entry_t      cur_q;
	logic [1:0]    st_q;
	logic [1:0]    st_d;
	logic [PW-1:0] pc_q;
	logic [PW-1:0] pc_d;
	logic [PW-1:0] pc_inc;
	slot_t         f_q, e_q, w_q;
	slot_t         f_d, e_d, w_d;
	logic [31:0]   cyc_q;
	logic [31:0]   cyc_d;
	logic          halt_q;
	logic          halt_d;
	logic          out_valid_q;
	logic          out_free;
	logic          emit;
	logic          emit_last;
	logic [31:0]   emit_val;
	logic          emit_dbz;
	logic          adv;
	logic          bubble;
	logic          rf_we;
	logic [31:0]   rf_wdata;
	logic          div_start;
	logic [3:0]    addr_a;
	logic [3:0]    addr_b;
	logic          in_a;
	logic          in_b;
	logic          in_d;
	logic [31:0]   va;
	logic [31:0]   vb;
	logic [31:0]   vb_op;
	logic [31:0]   alu_res;
	logic          eq;
	logic          taken;
	logic [PW-1:0] tmod [256];

	for (genvar g = 0; g < 256; g++) begin : g_tmod
		assign tmod[g] = PW'(g % PROG_DEPTH);
	end

	assign pc_inc = (pc_q == PW'(PROG_DEPTH - 1)) ? '0 : pc_q + PW'(1);

	assign addr_a = (q_head.cls == CLS_BRANCH) ? q_head.dest_reg : q_head.src_reg_a;
	assign addr_b = (q_head.cls == CLS_BRANCH) ? q_head.src_reg_a : q_head.src_reg_b;
	assign in_a   = (32'(addr_a) < NUM_REGS);
	assign in_b   = (32'(addr_b) < NUM_REGS);
	assign in_d   = (32'(cur_q.dest_reg) < NUM_REGS);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rda_q <= rf_q[addr_a[RW-1:0]];
			rdb_q <= rf_q[addr_b[RW-1:0]];
			cur_q <= q_head;
		end
		if (rf_we && in_d) rf_q[cur_q.dest_reg[RW-1:0]] <= rf_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= '0;
			rva_q    <= 1'b0;
			rvb_q    <= 1'b0;
		end else begin
			if (q_pop) begin
				rva_q <= in_a && rvalid_q[addr_a[RW-1:0]];
				rvb_q <= in_b && rvalid_q[addr_b[RW-1:0]];
			end
			if (rf_we && in_d) rvalid_q[cur_q.dest_reg[RW-1:0]] <= 1'b1;
		end
	end

	assign va    = rva_q ? rda_q : 32'd0;
	assign vb    = rvb_q ? rdb_q : 32'd0;
	assign vb_op = (cur_q.action == ACT_ADDI) ? cur_q.immediate : vb;
	assign eq    = (va == vb);
	assign taken = (cur_q.action == ACT_B) || ((cur_q.action == ACT_BEQ) && eq) ||
		((cur_q.action == ACT_BNQ) && !eq);

	always_comb begin
		case (cur_q.action)
			ACT_SUB: alu_res = va - vb_op;
			ACT_MUL: alu_res = va * vb_op;
			default: alu_res = va + vb_op;
		endcase
	end

	assign out_free = !out_valid_q || out_ready;
	assign div_req.start    = div_start;
	assign div_req.dividend = va;
	assign div_req.divisor  = vb;

	always_comb begin
		st_d      = st_q;
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_last = 1'b1;
		emit_val  = 32'd0;
		emit_dbz  = 1'b0;
		adv       = 1'b0;
		bubble    = 1'b0;
		rf_we     = 1'b0;
		rf_wdata  = 32'd0;
		div_start = 1'b0;
		pc_d      = pc_q;
		f_d       = f_q;
		e_d       = e_q;
		w_d       = w_q;
		cyc_d     = cyc_q;
		halt_d    = halt_q;
		case (st_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					st_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					st_d = S_IDLE;
					if (halt_q) begin
						emit = 1'b1;
					end else begin
						case (cur_q.cls)
							CLS_PRELOAD: begin
								rf_we    = 1'b1;
								rf_wdata = cur_q.immediate;
								emit_val = cur_q.immediate;
								emit     = 1'b1;
							end
							CLS_ALU: begin
								rf_we    = 1'b1;
								rf_wdata = alu_res;
								emit_val = alu_res;
								adv      = 1'b1;
								emit     = 1'b1;
							end
							CLS_DIV: begin
								if (vb == 32'd0) begin
									rf_we    = 1'b1;
									emit_dbz = 1'b1;
									adv      = 1'b1;
									emit     = 1'b1;
								end else begin
									div_start = 1'b1;
									st_d = S_DIV;
								end
							end
							CLS_END: begin
								bubble = 1'b1;
								halt_d = 1'b1;
								emit   = 1'b1;
							end
							CLS_BRANCH: begin
								pc_d      = taken ? tmod[cur_q.branch_target] : pc_inc;
								bubble    = 1'b1;
								emit_last = 1'b0;
								emit      = 1'b1;
								st_d      = S_BR2;
							end
							default: begin
								emit = 1'b1;
							end
						endcase
					end
				end
			end
			S_DIV: begin
				if (div_rsp.done && out_free) begin
					rf_we    = 1'b1;
					rf_wdata = div_rsp.quotient;
					emit_val = div_rsp.quotient;
					adv      = 1'b1;
					emit     = 1'b1;
					st_d     = S_IDLE;
				end
			end
			S_BR2: begin
				if (out_free) begin
					cyc_d = cyc_q + 32'd1;
					w_d   = '0;
					e_d   = f_q;
					f_d   = '{v: 1'b1, idx: pc_q};
					emit  = 1'b1;
					st_d  = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
		if (adv) begin
			pc_d  = pc_inc;
			cyc_d = cyc_q + 32'd1;
			w_d   = e_q;
			e_d   = f_q;
			f_d   = '{v: 1'b1, idx: pc_inc};
		end
		if (bubble) begin
			cyc_d = cyc_q + 32'd1;
			w_d   = e_q;
			e_d   = f_q;
			f_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			pc_q        <= '0;
			f_q         <= '0;
			e_q         <= '0;
			w_q         <= '0;
			cyc_q       <= '1;
			halt_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			pc_q   <= pc_d;
			f_q    <= f_d;
			e_q    <= e_d;
			w_q    <= w_d;
			cyc_q  <= cyc_d;
			halt_q <= halt_d;
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cycle_number    <= cyc_d;
			fetch_valid     <= f_d.v;
			fetch_index     <= f_d.v ? idx8(f_d.idx) : 8'd0;
			execute_valid   <= e_d.v;
			execute_index   <= e_d.v ? idx8(e_d.idx) : 8'd0;
			writeback_valid <= w_d.v;
			writeback_index <= w_d.v ? idx8(w_d.idx) : 8'd0;
			next_index      <= idx8(pc_d);
			written_value   <= emit_val;
			divide_by_zero  <= emit_dbz;
			halted          <= halt_d;
			last            <= emit_last;
		end
	end

	assign out_valid = out_valid_q;

	`TSP_ASSERT_IMP(a_pop_idle, clk, arst_n, q_pop, st_q == S_IDLE, "queue popped while busy")
	`TSP_ASSERT_NXT(a_branch_second, clk, arst_n, emit && !emit_last, st_q == S_BR2, "branch refetch missing")
	`TSP_ASSERT_IMP(a_div_not_halted, clk, arst_n, st_q == S_DIV, !halt_q, "divide after halt")
	`TSP_ASSERT_NXT(a_div_restart, clk, arst_n, div_req.start, !div_rsp.done, "stale quotient after start")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for three_stage_pipeline_core_step: a table of directed
// instructions, random instruction streams and a closing table, each report
// checked against a model of the core kept here. Depends on tsp_pkg and RTL.
module testbench
	import tsp_pkg::*;
();

	localparam int NUM_REGS = 10;
	localparam int PROG_DEPTH = 256;
	localparam logic [3:0] ACT_UNKNOWN_LO = 4'd10;
	localparam logic [3:0] ACT_UNKNOWN_HI = 4'd15;
	localparam int RANDOM_INSTRS = 1800;
	localparam int IDLE_PERCENT = 13;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam int OPENING_ROWS = 20;
	localparam int CLOSING_ROWS = 6;

	typedef struct packed {
		logic [3:0]  act;
		logic [3:0]  rd;
		logic [3:0]  ra;
		logic [3:0]  rb;
		logic [31:0] imm;
		logic [7:0]  tgt;
	} instr_t;

	typedef struct {
		instr_t      ins;
		bit          typed;
		logic [31:0] value;
		bit          dbz;
	} table_row_t;

	typedef struct {
		logic [31:0] cycle;
		logic        fetch_v;
		logic [7:0]  fetch_i;
		logic        exec_v;
		logic [7:0]  exec_i;
		logic        wb_v;
		logic [7:0]  wb_i;
		logic [7:0]  next_i;
		logic [31:0] value;
		logic        dbz;
		logic        halt;
		logic        fin;
	} report_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [3:0]         action;
	logic [3:0]         dest_reg;
	logic [3:0]         src_reg_a;
	logic [3:0]         src_reg_b;
	logic signed [31:0] immediate;
	logic [7:0]         branch_target;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [31:0]        cycle_number;
	logic               fetch_valid;
	logic [7:0]         fetch_index;
	logic               execute_valid;
	logic [7:0]         execute_index;
	logic               writeback_valid;
	logic [7:0]         writeback_index;
	logic [7:0]         next_index;
	logic signed [31:0] written_value;
	logic               divide_by_zero;
	logic               halted;
	logic               last;

	logic [31:0] gpr [NUM_REGS];
	logic [7:0]  pc;
	logic        fetch_v, exec_v, wb_v;
	logic [7:0]  fetch_i, exec_i, wb_i;
	logic [31:0] cycle_cnt;
	logic        halt_flag;

	report_t due_reports [$];
	int      failures = 0;
	int      instrs_sent = 0;
	int      reports_checked = 0;
	int      taken_branches = 0;
	int      untaken_branches = 0;
	int      zero_divides = 0;
	int      quiet_cycles = 0;
	int      hold_left = 0;
	bit      hold_used = 1'b0;
	bit      hold_wanted;
	bit      steady;

	table_row_t opening_rows [OPENING_ROWS] = '{
		'{'{ACT_PRELOAD, 4'd1, 4'd0, 4'd0, 32'h7FFFFFFF, 8'd0}, 1'b1, 32'h7FFFFFFF, 1'b0},
		'{'{ACT_PRELOAD, 4'd2, 4'd0, 4'd0, 32'h80000000, 8'd0}, 1'b1, 32'h80000000, 1'b0},
		'{'{ACT_PRELOAD, 4'd3, 4'd0, 4'd0, 32'hFFFFFFFF, 8'd0}, 1'b1, 32'hFFFFFFFF, 1'b0},
		'{'{ACT_PRELOAD, 4'd15, 4'd0, 4'd0, 32'h12345678, 8'd0}, 1'b1, 32'h12345678, 1'b0},
		'{'{ACT_ADD, 4'd4, 4'd1, 4'd3, 32'h0, 8'd0}, 1'b1, 32'h7FFFFFFE, 1'b0},
		'{'{ACT_ADDI, 4'd5, 4'd1, 4'd0, 32'h1, 8'd0}, 1'b1, 32'h80000000, 1'b0},
		'{'{ACT_SUB, 4'd6, 4'd2, 4'd1, 32'h0, 8'd0}, 1'b1, 32'h1, 1'b0},
		'{'{ACT_MUL, 4'd7, 4'd1, 4'd1, 32'h0, 8'd0}, 1'b1, 32'h1, 1'b0},
		'{'{ACT_DIV, 4'd8, 4'd2, 4'd3, 32'h0, 8'd0}, 1'b1, 32'h80000000, 1'b0},
		'{'{ACT_DIV, 4'd9, 4'd1, 4'd0, 32'h0, 8'd0}, 1'b1, 32'h0, 1'b1},
		'{'{ACT_DIV, 4'd8, 4'd3, 4'd1, 32'h0, 8'd0}, 1'b0, 32'h0, 1'b0},
		'{'{ACT_ADDI, 4'd15, 4'd1, 4'd0, 32'h1, 8'd0}, 1'b1, 32'h80000000, 1'b0},
		'{'{ACT_ADD, 4'd0, 4'd14, 4'd13, 32'h0, 8'd0}, 1'b1, 32'h0, 1'b0},
		'{'{ACT_BEQ, 4'd0, 4'd0, 4'd0, 32'h0, 8'd255}, 1'b1, 32'h0, 1'b0},
		'{'{ACT_ADD, 4'd0, 4'd0, 4'd0, 32'h0, 8'd0}, 1'b0, 32'h0, 1'b0},
		'{'{ACT_BNQ, 4'd1, 4'd2, 4'd0, 32'h0, 8'd128}, 1'b0, 32'h0, 1'b0},
		'{'{ACT_BEQ, 4'd1, 4'd2, 4'd0, 32'h0, 8'd7}, 1'b0, 32'h0, 1'b0},
		'{'{ACT_BNQ, 4'd0, 4'd11, 4'd0, 32'h0, 8'd9}, 1'b0, 32'h0, 1'b0},
		'{'{ACT_UNKNOWN_LO, 4'd1, 4'd1, 4'd1, 32'h1, 8'd1}, 1'b1, 32'h0, 1'b0},
		'{'{ACT_UNKNOWN_HI, 4'd1, 4'd1, 4'd1, 32'h1, 8'd1}, 1'b1, 32'h0, 1'b0}
	};

	table_row_t closing_rows [CLOSING_ROWS] = '{
		'{'{ACT_END, 4'd0, 4'd0, 4'd0, 32'h0, 8'd0}, 1'b1, 32'h0, 1'b0},
		'{'{ACT_ADD, 4'd4, 4'd1, 4'd2, 32'h0, 8'd0}, 1'b0, 32'h0, 1'b0},
		'{'{ACT_PRELOAD, 4'd1, 4'd0, 4'd0, 32'h55, 8'd0}, 1'b1, 32'h0, 1'b0},
		'{'{ACT_B, 4'd0, 4'd0, 4'd0, 32'h0, 8'd3}, 1'b1, 32'h0, 1'b0},
		'{'{ACT_DIV, 4'd5, 4'd0, 4'd0, 32'h0, 8'd0}, 1'b1, 32'h0, 1'b0},
		'{'{ACT_UNKNOWN_HI, 4'd0, 4'd0, 4'd0, 32'h0, 8'd0}, 1'b1, 32'h0, 1'b0}
	};

	three_stage_pipeline_core_step #(
		.NUM_REGS   (NUM_REGS),
		.PROG_DEPTH (PROG_DEPTH)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.dest_reg        (dest_reg),
		.src_reg_a       (src_reg_a),
		.src_reg_b       (src_reg_b),
		.immediate       (immediate),
		.branch_target   (branch_target),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.cycle_number    (cycle_number),
		.fetch_valid     (fetch_valid),
		.fetch_index     (fetch_index),
		.execute_valid   (execute_valid),
		.execute_index   (execute_index),
		.writeback_valid (writeback_valid),
		.writeback_index (writeback_index),
		.next_index      (next_index),
		.written_value   (written_value),
		.divide_by_zero  (divide_by_zero),
		.halted          (halted),
		.last            (last)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	function automatic logic [31:0] read_reg(logic [3:0] idx);
		if (idx < NUM_REGS) begin
			return gpr[idx];
		end
		return '0;
	endfunction

	function automatic void write_reg(logic [3:0] idx, logic [31:0] v);
		if (idx < NUM_REGS) begin
			gpr[idx] = v;
		end
	endfunction

	function automatic logic [7:0] pc_plus_one();
		return 8'((int'(pc) + 1) % PROG_DEPTH);
	endfunction

	function automatic report_t snapshot(logic [31:0] value, logic dbz, logic fin);
		report_t r;
		r.cycle = cycle_cnt;
		r.fetch_v = fetch_v;
		r.fetch_i = fetch_v ? fetch_i : 8'd0;
		r.exec_v = exec_v;
		r.exec_i = exec_v ? exec_i : 8'd0;
		r.wb_v = wb_v;
		r.wb_i = wb_v ? wb_i : 8'd0;
		r.next_i = pc;
		r.value = value;
		r.dbz = dbz;
		r.halt = halt_flag;
		r.fin = fin;
		return r;
	endfunction

	function automatic void advance_stages(logic new_v, logic [7:0] new_i);
		cycle_cnt = cycle_cnt + 32'd1;
		wb_v = exec_v;
		wb_i = exec_i;
		exec_v = fetch_v;
		exec_i = fetch_i;
		fetch_v = new_v;
		fetch_i = new_i;
	endfunction

	function automatic void execute_instr(input instr_t ins, output report_t reps [2],
			output int n);
		logic [31:0] va, vb, res;
		logic        dbz, equal, taken;
		longint      quo;
		res = '0;
		dbz = 1'b0;
		n = 1;
		if (halt_flag || ins.act > ACT_PRELOAD) begin
			reps[0] = snapshot('0, 1'b0, 1'b1);
		end else if (ins.act == ACT_PRELOAD) begin
			write_reg(ins.rd, ins.imm);
			reps[0] = snapshot(ins.imm, 1'b0, 1'b1);
		end else if (ins.act <= ACT_DIV) begin
			va = read_reg(ins.ra);
			vb = (ins.act == ACT_ADDI) ? ins.imm : read_reg(ins.rb);
			case (ins.act)
				ACT_ADD, ACT_ADDI: begin
					res = va + vb;
				end
				ACT_SUB: begin
					res = va - vb;
				end
				ACT_MUL: begin
					res = va * vb;
				end
				default: begin
					if (vb == '0) begin
						dbz = 1'b1;
						zero_divides++;
					end else begin
						quo = longint'($signed(va)) / longint'($signed(vb));
						res = quo[31:0];
					end
				end
			endcase
			write_reg(ins.rd, res);
			pc = pc_plus_one();
			advance_stages(1'b1, pc);
			reps[0] = snapshot(res, dbz, 1'b1);
		end else if (ins.act == ACT_END) begin
			advance_stages(1'b0, 8'd0);
			halt_flag = 1'b1;
			reps[0] = snapshot('0, 1'b0, 1'b1);
		end else begin
			equal = read_reg(ins.rd) == read_reg(ins.ra);
			taken = (ins.act == ACT_B) || (ins.act == ACT_BEQ && equal) ||
				(ins.act == ACT_BNQ && !equal);
			if (taken) begin
				pc = 8'(int'(ins.tgt) % PROG_DEPTH);
				taken_branches++;
			end else begin
				pc = pc_plus_one();
				untaken_branches++;
			end
			advance_stages(1'b0, 8'd0);
			reps[0] = snapshot('0, 1'b0, 1'b0);
			advance_stages(1'b1, pc);
			wb_v = 1'b0;
			wb_i = 8'd0;
			reps[1] = snapshot('0, 1'b0, 1'b1);
			n = 2;
		end
	endfunction

	function automatic logic [3:0] random_reg();
		if ($urandom_range(99) < 8) begin
			return 4'($urandom_range(15, NUM_REGS));
		end
		return 4'($urandom_range(NUM_REGS - 1, 0));
	endfunction

	function automatic logic [31:0] random_imm();
		int pick;
		pick = $urandom_range(9);
		case (pick)
			0: return 32'h80000000;
			1: return 32'h7FFFFFFF;
			2: return 32'hFFFFFFFF;
			3, 4, 5: return 32'($urandom_range(3));
			default: return $urandom;
		endcase
	endfunction

	function automatic instr_t random_instr();
		instr_t ins;
		int     pick;
		pick = $urandom_range(99);
		ins.rd = random_reg();
		ins.ra = random_reg();
		ins.rb = random_reg();
		ins.imm = random_imm();
		ins.tgt = 8'($urandom_range(255));
		if (pick < 15) begin
			ins.act = ACT_PRELOAD;
		end else if (pick < 30) begin
			ins.act = ACT_ADD;
		end else if (pick < 45) begin
			ins.act = ACT_ADDI;
		end else if (pick < 57) begin
			ins.act = ACT_SUB;
		end else if (pick < 69) begin
			ins.act = ACT_MUL;
		end else if (pick < 76) begin
			ins.act = ACT_DIV;
		end else if (pick < 82) begin
			ins.act = ACT_B;
		end else if (pick < 89) begin
			ins.act = ACT_BEQ;
		end else if (pick < 96) begin
			ins.act = ACT_BNQ;
		end else begin
			ins.act = 4'($urandom_range(ACT_UNKNOWN_HI, ACT_UNKNOWN_LO));
		end
		if ((ins.act == ACT_BEQ || ins.act == ACT_BNQ) && $urandom_range(99) < 30) begin
			ins.ra = ins.rd;
		end
		return ins;
	endfunction

	task automatic deliver(input instr_t ins, input bit typed, input logic [31:0] value,
			input bit dbz);
		int      gap;
		int      n;
		report_t reps [2];
		gap = 0;
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			gap++;
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= ins.act;
		dest_reg <= ins.rd;
		src_reg_a <= ins.ra;
		src_reg_b <= ins.rb;
		immediate <= ins.imm;
		branch_target <= ins.tgt;
		do @(posedge clk); while (!in_ready);
		execute_instr(ins, reps, n);
		for (int i = 0; i < n; i++) begin
			if (typed) begin
				reps[i].value = value;
				reps[i].dbz = dbz;
			end
			due_reports = {due_reports, reps[i]};
		end
		instrs_sent++;
	endtask

	function automatic void compare(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, field, want, got);
			failures++;
		end
	endfunction

	task automatic check_report();
		report_t want;
		if (due_reports.size() == 0) begin
			$display("%0t: report transaction with none expected, cycle_number %h",
				$time, cycle_number);
			failures++;
		end else begin
			want = due_reports.pop_front();
			compare("cycle_number", want.cycle, cycle_number);
			compare("fetch_valid", want.fetch_v, fetch_valid);
			compare("fetch_index", want.fetch_i, fetch_index);
			compare("execute_valid", want.exec_v, execute_valid);
			compare("execute_index", want.exec_i, execute_index);
			compare("writeback_valid", want.wb_v, writeback_valid);
			compare("writeback_index", want.wb_i, writeback_index);
			compare("next_index", want.next_i, next_index);
			compare("written_value", want.value, written_value);
			compare("divide_by_zero", want.dbz, divide_by_zero);
			compare("halted", want.halt, halted);
			compare("last", want.fin, last);
			reports_checked++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (out_valid && out_ready) begin
				check_report();
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_wanted && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_OFF_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = '0;
		dest_reg = '0;
		src_reg_a = '0;
		src_reg_b = '0;
		immediate = '0;
		branch_target = '0;
		steady = 1'b0;
		hold_wanted = 1'b0;
		for (int i = 0; i < NUM_REGS; i++) begin
			gpr[i] = '0;
		end
		pc = '0;
		fetch_v = 1'b0;
		exec_v = 1'b0;
		wb_v = 1'b0;
		fetch_i = '0;
		exec_i = '0;
		wb_i = '0;
		cycle_cnt = '1;
		halt_flag = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < OPENING_ROWS; i++) begin
			deliver(opening_rows[i].ins, opening_rows[i].typed, opening_rows[i].value,
				opening_rows[i].dbz);
		end
		for (int i = 0; i < RANDOM_INSTRS; i++) begin
			if (i == 500) begin
				steady <= 1'b1;
			end
			if (i == 800) begin
				steady <= 1'b0;
			end
			if (i == 1100) begin
				hold_wanted <= 1'b1;
			end
			deliver(random_instr(), 1'b0, '0, 1'b0);
		end
		for (int i = 0; i < CLOSING_ROWS; i++) begin
			deliver(closing_rows[i].ins, closing_rows[i].typed, closing_rows[i].value,
				closing_rows[i].dbz);
		end
		in_valid <= 1'b0;
		while (due_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d instructions (%0d from the table) and checked %0d reports.",
			instrs_sent, OPENING_ROWS + CLOSING_ROWS, reports_checked);
		$display("Saw %0d taken and %0d untaken branches, %0d divides by zero, halt at end.",
			taken_branches, untaken_branches, zero_divides);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: three_stage_pipeline_core_step.f
+incdir+src
src/tsp_pkg.sv
src/tsp_front.sv
src/tsp_div.sv
src/tsp_back.sv
src/three_stage_pipeline_core_step.sv
tb/testbench.sv
